### hw/rtl/per_key_send_rate_limiter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-key send rate limiter
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_SEND_RATE_LIMITER_ASSERT_SVH
`define PER_KEY_SEND_RATE_LIMITER_ASSERT_SVH

// same-cycle implication
`define PKSRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKSRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pksrl_pkg.sv
// ----------------------------------------------------------------------------
// pksrl_pkg
// Types, status codes and helpers of the per-key send rate limiter.
// ----------------------------------------------------------------------------
package pksrl_pkg;

  localparam int unsigned HeadW = 64;
  localparam int unsigned TailW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned IntvW = 16;
  localparam logic [IntvW-1:0] IntvReset = 16'd300;

  typedef enum logic [1:0] {
    ST_KNOWN = 2'd0,
    ST_NEW   = 2'd1,
    ST_SOON  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [HeadW-1:0] callsign_head;
    logic [TailW-1:0] callsign_tail;
    logic [TimeW-1:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic             allowed;
    status_e          status;
    logic [TimeW-1:0] remaining_seconds;
  } result_t;

  typedef struct packed {
    logic [HeadW-1:0] head;
    logic [TailW-1:0] tail;
    logic [TimeW-1:0] due;
  } entry_t;

  // now + interval, saturating at the 32-bit maximum
  function automatic logic [TimeW-1:0] due_after(input logic [TimeW-1:0] now,
                                                 input logic [IntvW-1:0] intv);
    logic [TimeW:0] sum;
    sum = {1'b0, now} + {{(TimeW+1-IntvW){1'b0}}, intv};
    due_after = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

endpackage

### hw/rtl/per_key_send_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_key_send_rate_limiter
// Per-key send rate limiter: a table of call-sign keys with due times and
// recency ranks, held in a key/due memory and a rank memory.
// Each request runs a search pass with one memory read per entry; a new key
//   that is stored also runs a rank pass with one read-modify-write per entry.
// Requests do not overlap: a new one is taken only while busy is low.
// Reset: all entries invalid, send_interval 300; memories keep no reset.
// ----------------------------------------------------------------------------
module per_key_send_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pksrl_pkg::IntvW-1:0]    cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  pksrl_pkg::req_t                req_i,
  output logic                           done_o,
  output pksrl_pkg::result_t             result_o
);
  import pksrl_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned RW = IW;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_RANK   = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic [IntvW-1:0] intv_q;
  req_t req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic hit_q, hit_d, free_q, free_d, vic_q, vic_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, vic_idx_q, vic_idx_d;
  logic [TimeW-1:0] hit_due_q, hit_due_d;
  logic [RW-1:0] vic_rank_q, vic_rank_d;
  logic done_q, done_d;
  result_t res_q, res_d;

  entry_t ent_mem [TABLE_ENTRIES];
  logic [RW-1:0] rk_mem [TABLE_ENTRIES];
  entry_t ent_rd_q;
  logic [RW-1:0] rk_rd_q;

  logic [IW-1:0] rd_addr;
  logic ent_we, rk_we;
  logic [IW-1:0] ent_waddr, rk_waddr;
  entry_t ent_wdata;
  logic [RW-1:0] rk_wdata;

  logic in_pass, pass_issue, pass_end, accept, cur_valid, key_eq;
  logic [TimeW-1:0] new_due;

  assign accept     = start && !busy;
  assign in_pass    = (st_q == S_SCAN) || (st_q == S_RANK);
  assign pass_issue = in_pass && (cnt_q < CW'(TABLE_ENTRIES));
  assign pass_end   = in_pass && !pass_issue && !rd_vld_q;
  assign rd_addr    = pass_issue ? cnt_q[IW-1:0] : '0;
  assign cur_valid  = valid_q[rd_idx_q];
  assign key_eq     = (ent_rd_q.head == req_q.callsign_head) &&
                      (ent_rd_q.tail == req_q.callsign_tail);
  assign new_due    = due_after(req_q.now_seconds, intv_q);

  always_comb begin
    st_d       = st_q;
    req_d      = req_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    valid_d    = valid_q;
    hit_d      = hit_q;
    free_d     = free_q;
    vic_d      = vic_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    vic_idx_d  = vic_idx_q;
    hit_due_d  = hit_due_q;
    vic_rank_d = vic_rank_q;
    done_d     = 1'b0;
    res_d      = res_q;
    ent_we     = 1'b0;
    ent_waddr  = hit_idx_q;
    ent_wdata  = '{head: req_q.callsign_head, tail: req_q.callsign_tail, due: new_due};
    rk_we      = 1'b0;
    rk_waddr   = rd_idx_q;
    rk_wdata   = rk_rd_q + RW'(1);

    if (pass_issue) begin
      rd_vld_d = 1'b1;
      rd_idx_d = cnt_q[IW-1:0];
      cnt_d    = cnt_q + CW'(1);
    end

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          st_d   = S_SCAN;
          req_d  = req_i;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          vic_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          if (cur_valid && key_eq) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_due_d = ent_rd_q.due;
          end
          if (!cur_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (cur_valid && (ent_rd_q.due <= req_q.now_seconds) &&
              (!vic_q || (rk_rd_q < vic_rank_q))) begin
            vic_d      = 1'b1;
            vic_idx_d  = rd_idx_q;
            vic_rank_d = rk_rd_q;
          end
        end
        if (pass_end) st_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_d.remaining_seconds = '0;
        if (hit_q) begin
          done_d = 1'b1;
          st_d   = S_IDLE;
          if (req_q.now_seconds >= hit_due_q) begin
            ent_we        = 1'b1;
            res_d.allowed = 1'b1;
            res_d.status  = ST_KNOWN;
          end else begin
            res_d.allowed           = 1'b0;
            res_d.status            = ST_SOON;
            res_d.remaining_seconds = hit_due_q - req_q.now_seconds;
          end
        end else if (!free_q) begin
          done_d        = 1'b1;
          st_d          = S_IDLE;
          res_d.allowed = 1'b0;
          res_d.status  = ST_FULL;
        end else if (new_due <= req_q.now_seconds) begin
          // new entry is its own victim: table unchanged
          done_d        = 1'b1;
          st_d          = S_IDLE;
          res_d.allowed = 1'b1;
          res_d.status  = ST_NEW;
        end else begin
          ent_we    = 1'b1;
          ent_waddr = free_idx_q;
          cnt_d     = '0;
          st_d      = S_RANK;
        end
      end
      S_RANK: begin
        if (rd_vld_q && cur_valid &&
            (!vic_q || ((rd_idx_q != vic_idx_q) && (rk_rd_q < vic_rank_q)))) begin
          rk_we = 1'b1;
        end
        if (pass_end) begin
          rk_we               = 1'b1;
          rk_waddr            = free_idx_q;
          rk_wdata            = '0;
          valid_d[free_idx_q] = 1'b1;
          if (vic_q) valid_d[vic_idx_q] = 1'b0;
          done_d                  = 1'b1;
          res_d.allowed           = 1'b1;
          res_d.status            = ST_NEW;
          res_d.remaining_seconds = '0;
          st_d                    = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      intv_q   <= IntvReset;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      vic_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      if (cfg_we_i) intv_q <= cfg_wdata_i;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      vic_q    <= vic_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    vic_idx_q  <= vic_idx_d;
    hit_due_q  <= hit_due_d;
    vic_rank_q <= vic_rank_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    ent_rd_q <= ent_mem[rd_addr];
    rk_rd_q  <= rk_mem[rd_addr];
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
  end

  assign busy     = (st_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`include "per_key_send_rate_limiter_assert.svh"

  `PKSRL_ASSERT_NXT(a_accept_busy, accept, busy, "busy not raised after start beat")
  `PKSRL_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while still busy")
  `PKSRL_ASSERT_IMP(a_rank_not_free, (st_q == S_RANK) && rd_vld_q && rk_we,
                    rk_waddr != free_idx_q, "rank pass wrote the slot being filled")
  `PKSRL_ASSERT_IMP(a_soon_nonzero, done_o && (result_o.status == ST_SOON),
                    (result_o.remaining_seconds != '0) && !result_o.allowed,
                    "too-soon result with zero remaining time")

endmodule

### tb/per_key_send_rate_limiter_test.sv
// ----------------------------------------------------------------------------
// per_key_send_rate_limiter_test
// Drives call-sign requests into the rate limiter and checks every result
// beat against a local table model: too-soon refusals with remaining time,
// new-key inserts with eviction of the newest stale entry, saturated due
// times, time wrap, zero and maximum intervals, and the full-table refusal.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module per_key_send_rate_limiter_test;
  import pksrl_pkg::*;

  localparam int Entries = 16;
  localparam int PoolSize = 20;
  localparam int QuietLimit = 2000;
  localparam logic [TimeW-1:0] Permanent = 32'hF000_0000;
  localparam logic [HeadW-1:0] HeadA = 64'h0123_4567_89AB_CDEF;
  localparam logic [TailW-1:0] TailA = 16'h4B31;

  class limiter_table_model;
    logic [IntvW-1:0] interval;
    bit               used [Entries];
    logic [HeadW-1:0] key_head [Entries];
    logic [TailW-1:0] key_tail [Entries];
    logic [TimeW-1:0] due [Entries];
    int unsigned      rank [Entries];
    result_t          pending_verdicts [$];
    int               errors;

    function new();
      interval = IntvReset;
      errors = 0;
      foreach (used[i]) begin
        used[i] = 1'b0;
        rank[i] = 0;
      end
    endfunction

    function int find_key(logic [HeadW-1:0] h, logic [TailW-1:0] t);
      foreach (used[i])
        if (used[i] && key_head[i] == h && key_tail[i] == t) return i;
      return -1;
    endfunction

    function int used_count();
      int n;
      n = 0;
      foreach (used[i]) n += int'(used[i]);
      return n;
    endfunction

    // latest due time among entries that time can still reach
    function logic [TimeW-1:0] latest_due();
      logic [TimeW-1:0] m;
      m = '0;
      foreach (used[i])
        if (used[i] && due[i] < Permanent && due[i] > m) m = due[i];
      return m;
    endfunction

    function logic [TimeW-1:0] next_due(logic [TimeW-1:0] now);
      logic [TimeW:0] sum;
      sum = {1'b0, now} + {{(TimeW+1-IntvW){1'b0}}, interval};
      return sum[TimeW] ? '1 : sum[TimeW-1:0];
    endfunction

    function void note_request(req_t r);
      int          hit;
      int          slot;
      int          victim;
      int unsigned gone;
      result_t     v;
      v = '0;
      v.status = ST_KNOWN;
      hit = find_key(r.callsign_head, r.callsign_tail);
      if (hit >= 0) begin
        if (r.now_seconds >= due[hit]) begin
          due[hit] = next_due(r.now_seconds);
          v.allowed = 1'b1;
        end else begin
          v.status = ST_SOON;
          v.remaining_seconds = due[hit] - r.now_seconds;
        end
      end else begin
        slot = -1;
        for (int i = Entries - 1; i >= 0; i--)
          if (!used[i]) slot = i;
        if (slot < 0) begin
          v.status = ST_FULL;
        end else begin
          foreach (used[i])
            if (used[i]) rank[i]++;
          used[slot] = 1'b1;
          key_head[slot] = r.callsign_head;
          key_tail[slot] = r.callsign_tail;
          due[slot] = next_due(r.now_seconds);
          rank[slot] = 0;
          victim = -1;
          foreach (used[i])
            if (used[i] && r.now_seconds >= due[i] &&
                (victim < 0 || rank[i] < rank[victim])) victim = i;
          if (victim >= 0) begin
            gone = rank[victim];
            used[victim] = 1'b0;
            rank[victim] = 0;
            foreach (used[i])
              if (used[i] && rank[i] > gone) rank[i]--;
          end
          v.allowed = 1'b1;
          v.status = ST_NEW;
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.allowed !== want.allowed) begin
        $error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.remaining_seconds !== want.remaining_seconds) begin
        $error("remaining_seconds: expected %0d, got %0d",
               want.remaining_seconds, got.remaining_seconds);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IntvW-1:0] cfg_wdata_i = '0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req_i = '0;
  logic             done_o;
  result_t          result_o;

  limiter_table_model table_model;
  logic [HeadW-1:0]   pool_head [PoolSize];
  logic [TailW-1:0]   pool_tail [PoolSize];
  logic [TimeW-1:0]   cursor;
  bit                 idle_mode = 1'b1;
  int                 quiet_cycles = 0;

  per_key_send_rate_limiter #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) table_model.check_verdict(result_o);
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("per_key_send_rate_limiter_test: done, errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [HeadW-1:0] h, input logic [TailW-1:0] t,
                              input logic [TimeW-1:0] now);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) idle_mode = !idle_mode;
    gap = idle_mode ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{callsign_head: h, callsign_tail: t, now_seconds: now};
    do @(posedge clk_i); while (busy);
    table_model.note_request(req_i);
  endtask

  // only while idle: drain results, let the tail of the last search pass
  task automatic write_interval(input logic [IntvW-1:0] v);
    start <= 1'b0;
    while (table_model.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_model.interval = v;
  endtask

  // mostly pool keys so hits and refusals are common; times stay below the
  // wrap so entries keep going stale and the table never fills here
  task automatic run_random(input int count);
    logic [HeadW-1:0] h;
    logic [TailW-1:0] t;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] d;
    int               hit;
    int               k;
    int               flip;
    int unsigned      intv;
    int unsigned      pick;
    for (int n = 0; n < count; n++) begin
      intv = 32'(table_model.interval);
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, PoolSize - 1);
      h = pool_head[k];
      t = pool_tail[k];
      if (pick >= 90) begin
        h = {$urandom, $urandom};
        t = TailW'($urandom);
      end else if (pick >= 78) begin
        flip = $urandom_range(0, HeadW + TailW - 1);
        if (flip < HeadW) h[flip] = ~h[flip];
        else t[flip-HeadW] = ~t[flip-HeadW];
      end
      hit = table_model.find_key(h, t);
      if (hit >= 0) begin
        d = table_model.due[hit];
        case ($urandom_range(0, 4))
          0: now = d - 1;
          1: now = d;
          2: now = d - $urandom_range(0, intv);
          3: now = d + $urandom_range(0, intv);
          default: now = cursor + $urandom_range(0, 2 * intv + 1);
        endcase
      end else if (table_model.used_count() >= Entries - 2) begin
        now = table_model.latest_due() + $urandom_range(0, 100);
      end else begin
        now = cursor + $urandom_range(0, intv);
      end
      if (now > cursor && now < Permanent) cursor = now;
      send_request(h, t, now);
    end
  endtask

  initial begin
    logic [IntvW-1:0] v;
    table_model = new();
    foreach (pool_head[i]) begin
      pool_head[i] = {$urandom, $urandom};
      pool_tail[i] = TailW'($urandom);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(HeadA, TailA, 32'd1000);
    send_request(HeadA, TailA, 32'd1100);
    send_request(HeadA, TailA, 32'd1299);
    send_request(HeadA, TailA, 32'd1300);
    // due time saturates, then time wraps past it
    send_request('1, '1, 32'hFFFF_FF00);
    send_request('1, '1, 32'hFFFF_FFFE);
    send_request('1, '1, 32'hFFFF_FFFF);
    send_request('1, '1, 32'd5);
    send_request('0, '0, 32'd0);
    send_request('0, '0, 32'd300);
    send_request(HeadA, TailA ^ 16'h0001, 32'd700);
    send_request(HeadA ^ 64'h8000_0000_0000_0000, TailA, 32'd700);

    cursor = 32'd100000;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: v = '0;
        1: v = '1;
        2: v = 16'd1;
        5: v = IntvReset;
        default: v = IntvW'($urandom_range(0, 65535));
      endcase
      write_interval(v);
      if (p == 0) begin
        // zero interval: a new key is freed right after its insert
        send_request(HeadA, TailA ^ 16'h8000, cursor);
        send_request(HeadA, TailA ^ 16'h8000, cursor);
      end
      run_random(100);
    end

    // fill the table; it stays full from here on
    write_interval('1);
    cursor = cursor + 200000;
    while (table_model.used_count() < Entries)
      send_request({$urandom, $urandom}, TailW'($urandom), cursor);
    for (int n = 0; n < 40; n++) begin
      case ($urandom_range(0, 2))
        0: send_request({$urandom, $urandom}, TailW'($urandom), $urandom);
        1: send_request(pool_head[n % PoolSize], pool_tail[n % PoolSize], $urandom);
        default: send_request(pool_head[n % PoolSize] ^ (64'd1 << $urandom_range(0, 63)),
                              pool_tail[n % PoolSize], $urandom);
      endcase
    end

    start <= 1'b0;
    while (table_model.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (table_model.errors == 0) begin
      $display("per_key_send_rate_limiter_test: done, clean");
    end else begin
      $display("per_key_send_rate_limiter_test: done, errors");
    end
    $finish;
  end

endmodule
